// ----- rtl/ppt_pkg.sv -----
package ppt_pkg;

    localparam int AREA_BITS  = 42;
    localparam int COUNT_BITS = 7;
    localparam int RSQ_BITS   = 34;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_AREA   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_SQ = 2'd2;

    // Control handed from the sequencer to the evaluator each cycle.
    typedef struct packed {
        logic valid;
        logic area;
        logic clear;
    } t_eval_ctl;

endpackage

// ----- rtl/ppt_if.sv -----
interface ppt_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, operation, point_x, point_y, end_x, end_y, input ready);
    modport sink (input valid, operation, point_x, point_y, end_x, end_y, output ready);
endinterface

interface ppt_out_if;
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic signed [41:0] double_area;
    logic [6:0]         segment_count;
    logic               rejected;

    modport source (output valid, inside_res, double_area, segment_count, rejected,
                    input ready);
    modport sink (input valid, inside_res, double_area, segment_count, rejected,
                  output ready);
endinterface

interface ppt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [33:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ppt_cell.sv -----
module ppt_cell #(
    parameter int SEG_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [SEG_BITS-1:0] i_d,
    output logic [SEG_BITS-1:0] o_q
);

    logic [SEG_BITS-1:0] r_seg;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_seg <= i_d;
        end
    end

    assign o_q = r_seg;

endmodule

// ----- rtl/ppt_eval.sv -----
module ppt_eval
    import ppt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_eval_ctl                    i_ctl,
    input  logic [4*COORD_BITS-1:0]      i_seg,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    output logic                         o_outside,
    output logic signed [AREA_BITS-1:0]  o_acc
);

    localparam int C = COORD_BITS;

    logic signed [C:0] sx, sy, tx, ty, px, py, cx, cy;
    logic signed [C:0] n_m1a, n_m1b, n_m2a, n_m2b;
    logic signed [C:0] r_m1a, r_m1b, r_m2a, r_m2b;
    logic signed [2*C+1:0] r_p1, r_p2;
    logic r_va, r_vb, r_area_a, r_area_b;
    logic r_outside;
    logic signed [AREA_BITS-1:0] r_acc;

    assign sx = {i_seg[C-1], i_seg[C-1:0]};
    assign sy = {i_seg[2*C-1], i_seg[2*C-1:C]};
    assign tx = {i_seg[3*C-1], i_seg[3*C-1:2*C]};
    assign ty = {i_seg[4*C-1], i_seg[4*C-1:3*C]};
    assign px = {i_px[C-1], i_px};
    assign py = {i_py[C-1], i_py};
    assign cx = {i_cx[C-1], i_cx};
    assign cy = {i_cy[C-1], i_cy};

    // Both queries need two products; only the operands differ.
    always_comb begin
        if (i_ctl.area) begin
            n_m1a = sx - cx;
            n_m1b = ty - cy;
            n_m2a = sy - cy;
            n_m2b = tx - cx;
        end else begin
            n_m1a = tx - sx;
            n_m1b = py - sy;
            n_m2a = ty - sy;
            n_m2b = px - sx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1a <= n_m1a;
        r_m1b <= n_m1b;
        r_m2a <= n_m2a;
        r_m2b <= n_m2b;
        r_area_a <= i_ctl.area;
        r_p1 <= r_m1a * r_m1b;
        r_p2 <= r_m2a * r_m2b;
        r_area_b <= r_area_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_outside <= 1'b0;
            r_acc <= '0;
        end else begin
            r_va <= i_ctl.valid;
            r_vb <= r_va;
            if (i_ctl.clear) begin
                r_outside <= 1'b0;
                r_acc <= '0;
            end else if (r_vb) begin
                if (r_area_b) begin
                    r_acc <= r_acc + AREA_BITS'(r_p1) - AREA_BITS'(r_p2);
                end else if (r_p1 < r_p2) begin
                    r_outside <= 1'b1;
                end
            end
        end
    end

    assign o_outside = r_outside;
    assign o_acc = r_acc;

endmodule

// ----- rtl/convex_polygon_point_test.sv -----
// Clear and append words finish at the accept edge, where the result is registered.
// Test and area words turn the segment ring once in full past the shared multiply stage;
// then the pipeline drains through ST_D1 and ST_D2, and ST_FIN loads the result.
// One word is in work at a time; the next word is taken once the result register is free.
// Reset empties the store and zeroes the centre and radius; segment data is not cleared.
module convex_polygon_point_test
    import ppt_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppt_in_if.sink          i_in,
    ppt_out_if.source       o_out,
    ppt_cfg_if.sink         i_cfg
);

    localparam int C  = COORD_BITS;
    localparam int SW = 4 * C;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int KW = $clog2(MAX_SEGMENTS);
    localparam logic [CW-1:0] FULL = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] LAST = CW'(MAX_SEGMENTS - 1);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_SEGMENTS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_D1   = 3'd2;
    localparam logic [2:0] ST_D2   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_count;
    logic [1:0] r_op;
    logic signed [C-1:0] r_px, r_py, r_cx, r_cy;
    logic [RSQ_BITS-1:0] r_rsq;
    logic [C:0] r_magx, r_magy;
    logic [35:0] r_sqx, r_sqy;

    logic r_ovalid, r_oinside, r_orej;
    logic signed [AREA_BITS-1:0] r_oarea;
    logic [COUNT_BITS-1:0] r_ocount;

    logic in_fire, out_fire, full, shift, set_ovalid;
    logic [SW-1:0] new_seg, head_d;
    logic [SW-1:0] ring [MAX_SEGMENTS];
    logic signed [C:0] dx, dy;
    logic [C:0] mx, my;
    logic [17:0] mx18, my18;
    logic [36:0] dsq;
    logic far, near, outside;
    logic signed [AREA_BITS-1:0] acc;
    t_eval_ctl ctl;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_ovalid && o_out.ready;
    assign full     = (r_count == FULL);
    assign i_in.ready = (r_state == ST_IDLE) && (!r_ovalid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    // A result is loaded either at the accept edge of a clear or append, or in ST_FIN after a turn.
    assign set_ovalid = (r_state == ST_FIN)
                     || (in_fire && (i_in.operation inside {OP_CLEAR, OP_APPEND}));

    assign new_seg = {i_in.end_y, i_in.end_x, i_in.point_y, i_in.point_x};
    assign shift = (r_state == ST_RUN)
                || (in_fire && i_in.operation == OP_APPEND && !full);
    assign head_d = (r_state == ST_RUN) ? ring[MAX_SEGMENTS-1] : new_seg;

    // Appends push in at the head, so outside a turn the filled entries are the first r_count cells.
    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_ring
        ppt_cell #(.SEG_BITS(SW)) u_cell (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_d    ((g == 0) ? head_d : ring[(g == 0) ? 0 : g - 1]),
            .o_q    (ring[g])
        );
    end

    // During a turn the tail cell holds entry LAST - r_k.
    assign ctl.valid = (r_state == ST_RUN) && ((LAST - CW'(r_k)) < r_count);
    assign ctl.area  = (r_op == OP_AREA);
    assign ctl.clear = in_fire;

    ppt_eval #(.COORD_BITS(C)) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_seg    (ring[MAX_SEGMENTS-1]),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .o_outside(outside),
        .o_acc    (acc)
    );

    assign dx = $signed({i_in.point_x[C-1], i_in.point_x}) - $signed({r_cx[C-1], r_cx});
    assign dy = $signed({i_in.point_y[C-1], i_in.point_y}) - $signed({r_cy[C-1], r_cy});
    assign mx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
    assign my = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
    assign mx18 = 18'(r_magx);
    assign my18 = 18'(r_magy);
    assign far  = ((r_magx >> 18) != '0) || ((r_magy >> 18) != '0);
    assign dsq  = 37'(r_sqx) + 37'(r_sqy);
    assign near = dsq < 37'(r_rsq);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= i_in.operation;
            r_px <= i_in.point_x;
            r_py <= i_in.point_y;
            r_magx <= mx;
            r_magy <= my;
        end
        r_sqx <= mx18 * mx18;
        r_sqy <= my18 * my18;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_rsq <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CENTER_X:  r_cx <= i_cfg.data[C-1:0];
                CFG_CENTER_Y:  r_cy <= i_cfg.data[C-1:0];
                CFG_RADIUS_SQ: r_rsq <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (set_ovalid) begin
                r_ovalid <= 1'b1;
            end else if (out_fire) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_k <= '0;
                        r_oinside <= 1'b0;
                        r_oarea <= '0;
                        r_orej <= 1'b0;
                        case (i_in.operation)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_ocount <= '0;
                            end
                            OP_APPEND: begin
                                if (full) begin
                                    r_orej <= 1'b1;
                                    r_ocount <= COUNT_BITS'(r_count);
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    r_ocount <= COUNT_BITS'(r_count + 1'b1);
                                end
                            end
                            default: r_state <= ST_RUN;
                        endcase
                    end
                end
                ST_RUN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= ST_D1;
                    end
                end
                ST_D1: r_state <= ST_D2;
                ST_D2: r_state <= ST_FIN;
                ST_FIN: begin
                    r_state <= ST_IDLE;
                    r_ocount <= COUNT_BITS'(r_count);
                    r_orej <= 1'b0;
                    r_oinside <= (r_op == OP_TEST) && (r_count != '0) && !far && near
                                 && !outside;
                    r_oarea <= (r_op == OP_AREA) ? acc : '0;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.inside_res = r_oinside;
    assign o_out.double_area = r_oarea;
    assign o_out.segment_count = r_ocount;
    assign o_out.rejected = r_orej;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import ppt_pkg::*;

    localparam int NUM_SEGS    = 64;
    localparam int DRAIN_WAIT  = NUM_SEGS + 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1100;
    localparam logic [33:0] RSQ_TOP = 34'd8589934592;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } word_t;

    typedef struct {
        logic        in_res;
        logic [41:0] area;
        logic [6:0]  count;
        logic        rej;
    } result_t;

    typedef struct {
        word_t   w;
        bit      typed;
        result_t res;
    } row_t;

    logic i_clk;
    logic i_rst_n;

    ppt_in_if #(.COORD_BITS(16)) in_if ();
    ppt_out_if out_if ();
    ppt_cfg_if cfg_if ();

    convex_polygon_point_test #(.MAX_SEGMENTS(NUM_SEGS), .COORD_BITS(16)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Predictor state.
    longint  poly_sx [NUM_SEGS];
    longint  poly_sy [NUM_SEGS];
    longint  poly_tx [NUM_SEGS];
    longint  poly_ty [NUM_SEGS];
    int      poly_count;
    longint  ctr_x;
    longint  ctr_y;
    longint  rad_sq;

    result_t expected_results[$];
    int      mismatches;
    int      cycles;
    bit      quiet;
    int      cur_row;
    row_t    rows[$];

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    function automatic bit point_is_inside(longint px, longint py);
        longint dx, dy;
        dx = px - ctr_x;
        dy = py - ctr_y;
        if (poly_count == 0) return 1'b0;
        if (dx * dx + dy * dy >= rad_sq) return 1'b0;
        for (int i = 0; i < poly_count; i++) begin
            if ((poly_tx[i] - poly_sx[i]) * (py - poly_sy[i]) <
                (poly_ty[i] - poly_sy[i]) * (px - poly_sx[i])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [41:0] fan_double_area();
        longint acc;
        acc = 0;
        for (int i = 0; i < poly_count; i++) begin
            acc += (poly_sx[i] - ctr_x) * (poly_ty[i] - ctr_y)
                 - (poly_sy[i] - ctr_y) * (poly_tx[i] - ctr_x);
        end
        return acc[41:0];
    endfunction

    // Applies one word to the predictor state and returns the result it causes.
    function automatic result_t apply_word(word_t w);
        result_t r;
        r = '{in_res: 1'b0, area: '0, count: '0, rej: 1'b0};
        case (w.op)
            OP_CLEAR: poly_count = 0;
            OP_APPEND: begin
                if (poly_count < NUM_SEGS) begin
                    poly_sx[poly_count] = w.px;
                    poly_sy[poly_count] = w.py;
                    poly_tx[poly_count] = w.ex;
                    poly_ty[poly_count] = w.ey;
                    poly_count++;
                end else begin
                    r.rej = 1'b1;
                end
            end
            OP_TEST: r.in_res = point_is_inside(w.px, w.py);
            default: r.area = fan_double_area();
        endcase
        r.count = poly_count[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        result_t exp_r, got;
        if (!i_rst_n) begin
            poly_count = 0;
            ctr_x = 0;
            ctr_y = 0;
            rad_sq = 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_CENTER_X:  ctr_x = $signed(cfg_if.data[15:0]);
                    CFG_CENTER_Y:  ctr_y = $signed(cfg_if.data[15:0]);
                    CFG_RADIUS_SQ: rad_sq = {30'd0, cfg_if.data};
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                exp_r = apply_word('{op: in_if.operation, px: in_if.point_x,
                                     py: in_if.point_y, ex: in_if.end_x, ey: in_if.end_y});
                if (cur_row >= 0 && rows[cur_row].typed) exp_r = rows[cur_row].res;
                expected_results.push_back(exp_r);
            end
            if (out_if.valid && out_if.ready) begin
                got = '{in_res: out_if.inside_res, area: out_if.double_area,
                        count: out_if.segment_count, rej: out_if.rejected};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp in=%0b area=%0d cnt=%0d rej=%0b, ",
                                      "got in=%0b area=%0d cnt=%0d rej=%0b"},
                                     exp_r.in_res, $signed(exp_r.area), exp_r.count,
                                     exp_r.rej, got.in_res, $signed(got.area), got.count,
                                     got.rej);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic put_word(word_t w, int row);
        while (!quiet && $urandom_range(99) < 38) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= w.op;
        in_if.point_x   <= w.px;
        in_if.point_y   <= w.py;
        in_if.end_x     <= w.ex;
        in_if.end_y     <= w.ey;
        cur_row         <= row;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Registers change only once the block has drained every word.
    task automatic write_reg(logic [1:0] idx, logic [33:0] value);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic word_t mk(logic [1:0] op, int px, int py, int ex, int ey);
        return '{op: op, px: px[15:0], py: py[15:0], ex: ex[15:0], ey: ey[15:0]};
    endfunction

    function automatic logic signed [15:0] clamp16(real v);
        if (v > 32767.0) return 16'sd32767;
        if (v < -32768.0) return -16'sd32768;
        return 16'($rtoi(v));
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(word_t w, bit typed, result_t r);
        rows.push_back('{w: w, typed: typed, res: r});
    endtask

    initial begin
        result_t z;
        word_t   w;
        int      n_sides, extra, sent;
        real     rad, ang, cxr, cyr;
        logic signed [15:0] vx [NUM_SEGS];
        logic signed [15:0] vy [NUM_SEGS];

        z = '{in_res: 1'b0, area: '0, count: '0, rej: 1'b0};
        quiet = 1'b0;
        cur_row = -1;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.operation = OP_CLEAR;
        in_if.point_x = '0;
        in_if.point_y = '0;
        in_if.end_x = '0;
        in_if.end_y = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_CENTER_X;
        cfg_if.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset settings.
        add_row(mk(OP_TEST, 0, 0, 0, 0), 1, z);
        add_row(mk(OP_AREA, 0, 0, 0, 0), 1, z);
        add_row(mk(OP_CLEAR, 0, 0, 0, 0), 1, z);
        add_row(mk(OP_APPEND, -32768, 32767, 32767, -32768), 1,
                '{in_res: 1'b0, area: '0, count: 7'd1, rej: 1'b0});
        add_row(mk(OP_AREA, 0, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, 0, 0, 0, 0), 1, '{in_res: 1'b0, area: '0, count: 7'd1, rej: 1'b0});
        foreach (rows[i]) put_word(rows[i].w, i);
        write_reg(CFG_RADIUS_SQ, RSQ_TOP);
        rows.delete();

        // Square around the origin, a degenerate segment, and points on and off the edges.
        add_row(mk(OP_CLEAR, 0, 0, 0, 0), 1, z);
        add_row(mk(OP_APPEND, -100, -100, 100, -100), 0, z);
        add_row(mk(OP_APPEND, 100, -100, 100, 100), 0, z);
        add_row(mk(OP_APPEND, 100, 100, -100, 100), 0, z);
        add_row(mk(OP_APPEND, -100, 100, -100, -100), 0, z);
        add_row(mk(OP_APPEND, 5, 5, 5, 5), 0, z);
        add_row(mk(OP_TEST, 0, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, 100, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, 101, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, 100, 100, 0, 0), 0, z);
        add_row(mk(OP_TEST, 32767, -32768, 0, 0), 0, z);
        add_row(mk(OP_AREA, 0, 0, 0, 0), 0, z);
        foreach (rows[i]) put_word(rows[i].w, i);
        write_reg(CFG_RADIUS_SQ, 34'd10000);
        rows.delete();
        add_row(mk(OP_TEST, 100, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, 99, 0, 0, 0), 0, z);
        add_row(mk(OP_TEST, -32768, -32768, 0, 0), 0, z);
        foreach (rows[i]) put_word(rows[i].w, i);
        cur_row <= -1;

        // Random part: phases of new settings, a convex polygon, then queries.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            quiet = (sent > 400 && sent < 520);
            write_reg(CFG_CENTER_X, {18'd0, pick_coord()});
            write_reg(CFG_CENTER_Y, {18'd0, pick_coord()});
            case ($urandom_range(5))
                0: write_reg(CFG_RADIUS_SQ, 34'd0);
                1: write_reg(CFG_RADIUS_SQ, RSQ_TOP);
                2: write_reg(CFG_RADIUS_SQ, 34'({$urandom, $urandom}));
                default: write_reg(CFG_RADIUS_SQ, 34'($urandom_range(4000000)));
            endcase
            cxr = $itor(ctr_x);
            cyr = $itor(ctr_y);
            rad = $itor($urandom_range(2000, 20));
            n_sides = ($urandom_range(7) == 0) ? NUM_SEGS : $urandom_range(8, 3);
            extra = (n_sides == NUM_SEGS) ? $urandom_range(3, 1) : 0;
            for (int k = 0; k < n_sides; k++) begin
                ang = 6.283185307 * k / n_sides;
                vx[k] = clamp16(cxr + rad * $cos(ang));
                vy[k] = clamp16(cyr + rad * $sin(ang));
            end
            put_word(mk(OP_CLEAR, 0, 0, 0, 0), -1);
            sent++;
            for (int k = 0; k < n_sides + extra; k++) begin
                w = mk(OP_APPEND, vx[k % n_sides], vy[k % n_sides],
                       vx[(k + 1) % n_sides], vy[(k + 1) % n_sides]);
                if ($urandom_range(19) == 0) w.ex = w.px;
                put_word(w, -1);
                sent++;
            end
            for (int k = 0; k < 20; k++) begin
                case ($urandom_range(9))
                    0: w = mk(2'($urandom), $urandom, $urandom, $urandom, $urandom);
                    1: w = mk(OP_AREA, $urandom, $urandom, $urandom, $urandom);
                    default: w = mk(OP_TEST,
                                    clamp16(cxr + rad * ($itor($urandom_range(2600)) / 1000.0 - 1.3)),
                                    clamp16(cyr + rad * ($itor($urandom_range(2600)) / 1000.0 - 1.3)),
                                    $urandom, $urandom);
                endcase
                put_word(w, -1);
                sent++;
            end
        end
        quiet = 1'b0;
        in_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
